// File: hw/rtl/ubso_pkg.sv
// Shared types and constants for the unaligned bit-string OR block.
package ubso_pkg;

    // Byte geometry (fixed by the data fields)
    localparam int BYTE_BITS = 8;
    localparam int MAX_LEN   = 8192;

    // Request kinds carried on s_tuser
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SOURCE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET_START = 2'd0;
    localparam logic [1:0] CFG_SOURCE_OFS   = 2'd1;
    localparam logic [1:0] CFG_BIT_LENGTH   = 2'd2;

    // Result queue geometry
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PW    = 2;
    localparam int OUT_CW    = 3;

    // Memory operation issued to the read-modify-write stage
    typedef enum logic [1:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_OR,
        UOP_READ
    } uop_kind_t;

    typedef struct packed {
        uop_kind_t  kind;
        logic [7:0] val;
        logic       last;     // this op closes the beat's result
        logic       op_done;
        logic       overrun;
    } uop_ctl_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       op_done;
        logic       overrun;
    } res_t;

endpackage

// File: hw/rtl/ubso_rmw.sv
// Target byte store with a registered read and a read-modify-write stage.
module ubso_rmw #(
    parameter int STORE_BYTES = 1024,
    parameter int AW          = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              uop_valid,
    input  logic [AW-1:0]     uop_addr,
    input  ubso_pkg::uop_ctl_t uop_ctl,
    output logic              res_valid,
    output ubso_pkg::res_t    res
);
    import ubso_pkg::*;

    logic [7:0]  store_mem [STORE_BYTES];
    logic [7:0]  rd_reg;

    logic        s2_valid_reg;
    logic [AW-1:0] s2_addr_reg;
    uop_ctl_t    s2_ctl_reg;

    logic        fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [7:0]  fwd_data_reg;

    logic        wr_en;
    logic [7:0]  wr_data;
    logic [7:0]  cur_byte;
    logic [7:0]  rd_out;

    // Store: registered read, write from the modify stage
    always_ff @(posedge aclk) begin
        if (uop_valid) begin
            rd_reg <= store_mem[uop_addr];
        end
        if (wr_en) begin
            store_mem[s2_addr_reg] <= wr_data;
        end
    end

    // Modify stage and one-deep write forwarding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg  <= uop_valid;
            fwd_valid_reg <= wr_en;
        end
        s2_addr_reg  <= uop_addr;
        s2_ctl_reg   <= uop_ctl;
        fwd_addr_reg <= s2_addr_reg;
        fwd_data_reg <= wr_data;
    end

    // The write issued last cycle is not yet visible in rd_reg
    assign cur_byte = (fwd_valid_reg && fwd_addr_reg == s2_addr_reg) ? fwd_data_reg : rd_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_data = cur_byte;
        rd_out  = 8'h00;
        if (s2_valid_reg) begin
            case (s2_ctl_reg.kind)
                UOP_LOAD: begin
                    wr_en   = 1'b1;
                    wr_data = s2_ctl_reg.val;
                end
                UOP_OR: begin
                    wr_en   = 1'b1;
                    wr_data = cur_byte | s2_ctl_reg.val;
                end
                UOP_READ: begin
                    rd_out = cur_byte;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    assign res_valid     = s2_valid_reg && s2_ctl_reg.last;
    assign res.read_data = rd_out;
    assign res.op_done   = s2_ctl_reg.op_done;
    assign res.overrun   = s2_ctl_reg.overrun;

endmodule

// File: hw/rtl/unaligned_bit_string_or.sv
// Unaligned bit-string OR top level: request decode, bit alignment and result queue.
//
// Each beat on s_ is one request (s_tuser: load target byte, next source byte or read
// target byte) and yields exactly one queued beat on m_. The block takes one request per
// cycle while the result queue has room; a source byte that completes the string and
// spills bits into a second target byte holds s_tready low for one extra cycle, as each
// target byte update is a read-modify-write through the store's single write port. Writes
// to the configuration port restart the source stream; the user must make them only
// while no request is in flight, which the block does not enforce. Source bits are
// funnel-shifted against the previous masked source byte; bit 0 is the MSB of a byte.
module unaligned_bit_string_or #(
    parameter int STORE_BYTES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data,
    // requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] byte_address, [17:10] data_byte, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] read_data, [8] op_done, [9] overrun, rest zero
);
    import ubso_pkg::*;

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [16:0] STORE_LIM = 17'(STORE_BYTES);

    // configuration and stream state
    logic [12:0] tsb_reg;
    logic [2:0]  sbo_reg;
    logic [13:0] len_reg;
    logic [7:0]  carry_reg;
    logic [10:0] taken_reg;

    // second target update of a final source byte
    logic          pend_valid_reg;
    logic [AW-1:0] pend_addr_reg;
    uop_ctl_t      pend_ctl_reg;

    // result queue
    res_t              q_mem [OUT_DEPTH];
    logic [OUT_PW-1:0] q_wr_reg;
    logic [OUT_PW-1:0] q_rd_reg;
    logic [OUT_CW-1:0] q_cnt_reg;
    logic [OUT_CW-1:0] resv_reg;   // queue slots promised to accepted beats

    logic        s_accept;
    logic        m_accept;
    logic [9:0]  byte_address;
    logic [7:0]  data_byte;

    logic [13:0] len_c;
    logic [14:0] span;
    logic [10:0] need;
    logic        in_run;
    logic [14:0] rem;
    logic [3:0]  end_bit;
    logic [2:0]  lo_bit;
    logic [7:0]  mask;
    logic [7:0]  m_byte;
    logic [14:0] u_pos;
    logic [2:0]  r_sh;
    logic [11:0] a_idx;
    logic [16:0] a_ext;
    logic [16:0] am1_ext;
    logic [16:0] req_ext;
    logic        final_byte;

    logic [AW-1:0] uop0_addr;
    uop_ctl_t      uop0_ctl;
    logic          need_second;
    logic [AW-1:0] uop1_addr;
    uop_ctl_t      uop1_ctl;

    logic          iss_valid;
    logic [AW-1:0] iss_addr;
    uop_ctl_t      iss_ctl;

    logic          res_valid;
    res_t          res;
    res_t          q_head;

    assign byte_address = s_tdata[9:0];
    assign data_byte    = s_tdata[17:10];

    assign s_tready = !pend_valid_reg && (resv_reg < OUT_CW'(OUT_DEPTH));
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_accept = m_tvalid && m_tready;

    // Source byte alignment: mask to the string, then locate the target byte pair
    always_comb begin
        len_c      = (len_reg > 14'(MAX_LEN)) ? 14'(MAX_LEN) : len_reg;
        span       = 15'(sbo_reg) + 15'(len_c);
        need       = (len_c == '0) ? 11'd0 : 11'(((span - 15'd1) >> 3) + 15'd1);
        in_run     = (taken_reg < need);
        rem        = span - {1'b0, taken_reg, 3'b000};
        end_bit    = (rem >= 15'd8) ? 4'd8 : rem[3:0];
        lo_bit     = (taken_reg == '0) ? sbo_reg : 3'd0;
        mask       = (8'hff >> lo_bit) & 8'(8'hff << (4'd8 - end_bit));
        m_byte     = data_byte & mask;
        u_pos      = 15'(tsb_reg) + 15'd8 - 15'(sbo_reg) + {1'b0, taken_reg, 3'b000};
        r_sh       = u_pos[2:0];
        a_idx      = u_pos[14:3];
        a_ext      = 17'(a_idx);
        am1_ext    = 17'(a_idx) - 17'd1;
        req_ext    = 17'(byte_address);
        final_byte = (11'(taken_reg + 11'd1) == need);
    end

    // Request decode into one or two store operations
    always_comb begin
        uop0_addr         = req_ext[AW-1:0];
        uop0_ctl.kind     = UOP_NOP;
        uop0_ctl.val      = data_byte;
        uop0_ctl.last     = 1'b1;
        uop0_ctl.op_done  = 1'b0;
        uop0_ctl.overrun  = 1'b0;
        need_second       = 1'b0;
        uop1_addr         = a_ext[AW-1:0];
        uop1_ctl.kind     = UOP_NOP;
        uop1_ctl.val      = 8'(m_byte << (4'd8 - {1'b0, r_sh}));
        uop1_ctl.last     = 1'b1;
        uop1_ctl.op_done  = 1'b1;
        uop1_ctl.overrun  = 1'b0;
        case (s_tuser)
            REQ_LOAD: begin
                if (req_ext < STORE_LIM) begin
                    uop0_ctl.kind = UOP_LOAD;
                end
            end
            REQ_READ: begin
                if (req_ext < STORE_LIM) begin
                    uop0_ctl.kind = UOP_READ;
                end
            end
            REQ_SOURCE: begin
                if (!in_run) begin
                    uop0_ctl.overrun = 1'b1;
                end else begin
                    uop0_addr    = am1_ext[AW-1:0];
                    uop0_ctl.val = 8'({carry_reg, m_byte} >> r_sh);
                    if (a_idx != '0 && am1_ext < STORE_LIM) begin
                        uop0_ctl.kind = UOP_OR;
                    end
                    if (final_byte) begin
                        if (r_sh != '0) begin
                            need_second   = 1'b1;
                            uop0_ctl.last = 1'b0;
                            if (a_ext < STORE_LIM) begin
                                uop1_ctl.kind = UOP_OR;
                            end
                        end else begin
                            uop0_ctl.op_done = 1'b1;
                        end
                    end
                end
            end
            default: begin
                uop0_ctl.kind = UOP_NOP;
            end
        endcase
    end

    // Issue: the held second update goes first
    always_comb begin
        if (pend_valid_reg) begin
            iss_valid = 1'b1;
            iss_addr  = pend_addr_reg;
            iss_ctl   = pend_ctl_reg;
        end else begin
            iss_valid = s_accept;
            iss_addr  = uop0_addr;
            iss_ctl   = uop0_ctl;
        end
    end

    // Configuration, stream state and the held update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsb_reg        <= '0;
            sbo_reg        <= '0;
            len_reg        <= 14'd1;
            carry_reg      <= '0;
            taken_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= s_accept && need_second && (s_tuser == REQ_SOURCE);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TARGET_START: begin
                        tsb_reg   <= cfg_data[12:0];
                        carry_reg <= '0;
                        taken_reg <= '0;
                    end
                    CFG_SOURCE_OFS: begin
                        sbo_reg   <= cfg_data[2:0];
                        carry_reg <= '0;
                        taken_reg <= '0;
                    end
                    CFG_BIT_LENGTH: begin
                        len_reg   <= cfg_data;
                        carry_reg <= '0;
                        taken_reg <= '0;
                    end
                    default: begin
                        len_reg <= len_reg;
                    end
                endcase
            end else if (s_accept && s_tuser == REQ_SOURCE && in_run) begin
                carry_reg <= m_byte;
                taken_reg <= taken_reg + 11'd1;
            end
        end
        pend_addr_reg <= uop1_addr;
        pend_ctl_reg  <= uop1_ctl;
    end

    ubso_rmw #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW)
    ) u_rmw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .uop_valid (iss_valid),
        .uop_addr  (iss_addr),
        .uop_ctl   (iss_ctl),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result queue; slots are reserved when a beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
            resv_reg  <= '0;
        end else begin
            if (res_valid) begin
                q_wr_reg <= q_wr_reg + OUT_PW'(1);
            end
            if (m_accept) begin
                q_rd_reg <= q_rd_reg + OUT_PW'(1);
            end
            q_cnt_reg <= q_cnt_reg + OUT_CW'(res_valid) - OUT_CW'(m_accept);
            resv_reg  <= resv_reg + OUT_CW'(s_accept) - OUT_CW'(m_accept);
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            q_mem[q_wr_reg] <= res;
        end
    end

    assign q_head  = q_mem[q_rd_reg];
    assign m_tdata = {6'b000000, q_head.overrun, q_head.op_done, q_head.read_data};

endmodule

// File: hw/rtl/ubso_check.sv
// Port-level checks for the unaligned bit-string OR block, bound to the top level.
module ubso_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A beat cannot both finish the string and overrun it
    a_done_ovr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
        else $error("op_done and overrun together");

    // Read data only on read beats, which carry no stream flags
    a_read_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[7:0] != 8'h00) |-> (!m_tdata[8] && !m_tdata[9]))
        else $error("read data with stream flags");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind unaligned_bit_string_or ubso_check u_ubso_check (.*);
